// ----- src/kfl_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, widths and helpers for the keyframe translation sampler.
// No dependencies; every other source file refers to this package.
package kfl_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int POS_W        = 17;
    localparam int COORD_W      = 32;
    localparam int PHASE_W      = 24;
    localparam int KIDX_W       = 6;
    localparam int KCNT_W       = 7;
    localparam int NUM_W        = POS_W + 1;
    localparam int DIFF_W       = COORD_W + 1;
    localparam int PROD_W       = DIFF_W + NUM_W;
    localparam int DVD_W        = PROD_W - 1;
    localparam int DVS_W        = POS_W;
    localparam int RES_W        = DVD_W + 3;

    localparam logic [POS_W-1:0] UNIT_POS = 17'h10000;

    localparam logic ACT_LOAD   = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]          pos;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } key_ent_t;

    typedef struct packed {
        logic             start;
        logic [DVD_W-1:0] dividend;
        logic [DVS_W-1:0] divisor;
    } div_req_t;

    typedef enum logic [8:0] {
        ST_IDLE = 9'b000000001,
        ST_CUR  = 9'b000000010,
        ST_NXT  = 9'b000000100,
        ST_RDC  = 9'b000001000,
        ST_RD0  = 9'b000010000,
        ST_MUL  = 9'b000100000,
        ST_PREP = 9'b001000000,
        ST_DIV  = 9'b010000000,
        ST_FIN  = 9'b100000000
    } seq_state_t;

    function automatic logic signed [COORD_W-1:0] axis_of(input key_ent_t e, input int a);
        logic signed [COORD_W-1:0] v;
        if (a == 0)
        begin
            v = e.x;
        end
        else if (a == 1)
        begin
            v = e.y;
        end
        else
        begin
            v = e.z;
        end
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] sat32(input logic signed [RES_W-1:0] v);
        logic [COORD_W-1:0] r;
        if (v > $signed(RES_W'(32'h7fffffff)))
        begin
            r = 32'h7fffffff;
        end
        else if (v < -$signed(RES_W'(33'h080000000)))
        begin
            r = 32'h80000000;
        end
        else
        begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- src/kfl_key_ram.sv -----
`timescale 1ns / 1ps
// Keyframe table: one write port and one read port with registered read data.
// Depends on kfl_pkg for the entry type.
module kfl_key_ram #(
    parameter int DEPTH = kfl_pkg::MAX_KEYS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic              clk,
    input  logic              we,
    input  logic [AW-1:0]     waddr,
    input  kfl_pkg::key_ent_t wdata,
    input  logic [AW-1:0]     raddr,
    output kfl_pkg::key_ent_t rdata
);

    kfl_pkg::key_ent_t mem [DEPTH];
    kfl_pkg::key_ent_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- src/kfl_divider.sv -----
`timescale 1ns / 1ps
// Restoring divider producing one quotient bit per cycle.
// Depends on kfl_pkg for widths and the request struct.
module kfl_divider (
    input  logic                         clk,
    input  logic                         rst_n,
    input  kfl_pkg::div_req_t            req,
    output logic                         busy,
    output logic [kfl_pkg::DVD_W-1:0]    quotient
);

    localparam int CW = $clog2(kfl_pkg::DVD_W + 1);

    logic [kfl_pkg::DVS_W-1:0] rem_reg, rem_next;
    logic [kfl_pkg::DVD_W-1:0] quo_reg, quo_next;
    logic [kfl_pkg::DVS_W-1:0] dvs_reg, dvs_next;
    logic [CW-1:0]             cnt_reg, cnt_next;
    logic                      busy_reg, busy_next;

    always_comb
    begin
        logic [kfl_pkg::DVS_W:0]   rem_sh;
        logic [kfl_pkg::DVS_W+1:0] diff;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        rem_sh    = {rem_reg, quo_reg[kfl_pkg::DVD_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, dvs_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
            cnt_next  = CW'(kfl_pkg::DVD_W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[kfl_pkg::DVS_W+1])
            begin
                rem_next = diff[kfl_pkg::DVS_W-1:0];
                quo_next = {quo_reg[kfl_pkg::DVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[kfl_pkg::DVS_W-1:0];
                quo_next = {quo_reg[kfl_pkg::DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ----- src/keyframe_translation_lerp_sampler.sv -----
`timescale 1ns / 1ps
// Top level of the keyframe translation sampler with linear interpolation.
// Depends on kfl_pkg, kfl_key_ram and kfl_divider.
//
// A load word writes one key into the table when it is taken. A sample word
// reads the table one entry per cycle: one read for the cursor key, one per key
// the cursor walks over, then the segment start and key 0. The ratio then takes
// a multiply step, a setup step, the bit-serial divider (the three axes divide
// side by side) plus a step to see it finish, and a step to write the result
// register; a segment of zero length goes from the key 0 read straight to the
// result write. The single table read port sets the walk time and the divider
// sets the rest. A finished result waits in the output register while the next
// word is taken, and a sample that ends while that result is still stalled holds
// in its last step.
module keyframe_translation_lerp_sampler #(
    parameter int MAX_KEYS = kfl_pkg::MAX_KEYS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [kfl_pkg::KCNT_W-1:0]          key_count,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  logic                                action,
    input  logic [kfl_pkg::KIDX_W-1:0]          key_index,
    input  logic [kfl_pkg::POS_W-1:0]           key_position,
    input  logic signed [kfl_pkg::COORD_W-1:0]  key_x,
    input  logic signed [kfl_pkg::COORD_W-1:0]  key_y,
    input  logic signed [kfl_pkg::COORD_W-1:0]  key_z,
    input  logic signed [kfl_pkg::PHASE_W-1:0]  phase,
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [kfl_pkg::COORD_W-1:0]  out_x,
    output logic signed [kfl_pkg::COORD_W-1:0]  out_y,
    output logic signed [kfl_pkg::COORD_W-1:0]  out_z,
    output logic                                zero_span
);

    localparam int IW = $clog2(MAX_KEYS);

    kfl_pkg::seq_state_t state_reg, state_next;

    logic [kfl_pkg::KCNT_W-1:0] kc_reg, kc_next;
    logic [IW-1:0] cursor_reg, cursor_next;
    logic [IW-1:0] c_reg, c_next, n_reg, n_next, last;
    logic [kfl_pkg::POS_W-1:0] p_reg, p_next, posc_reg, posc_next, posn_reg, posn_next;
    logic [kfl_pkg::POS_W-1:0] p_wrap;
    kfl_pkg::key_ent_t ent_c_reg, ent_c_next, ent_n_reg, ent_n_next;
    logic signed [kfl_pkg::NUM_W-1:0] num_reg, num_next, den_reg, den_next;
    logic signed [kfl_pkg::DIFF_W-1:0] base_reg [3];
    logic signed [kfl_pkg::DIFF_W-1:0] base_next [3];
    logic signed [kfl_pkg::DIFF_W-1:0] diff_reg [3];
    logic signed [kfl_pkg::DIFF_W-1:0] diff_next [3];
    logic signed [kfl_pkg::PROD_W-1:0] prod_reg [3];
    logic signed [kfl_pkg::PROD_W-1:0] prod_next [3];
    logic [2:0] neg_reg, neg_next;
    logic zero_reg, zero_next;
    logic [kfl_pkg::COORD_W-1:0] ox_reg, ox_next, oy_reg, oy_next, oz_reg, oz_next;
    logic zs_reg, zs_next;
    logic ov_reg, ov_next;

    logic mem_we;
    logic [IW-1:0] rd_addr, wr_addr;
    kfl_pkg::key_ent_t wr_data, rd_data;

    kfl_pkg::div_req_t div_req [3];
    logic [2:0] div_busy;
    logic [kfl_pkg::DVD_W-1:0] div_quo [3];

    function automatic logic [IW-1:0] last_of(input logic [kfl_pkg::KCNT_W-1:0] kc);
        logic [IW-1:0] r;
        if (kc < kfl_pkg::KCNT_W'(2))
        begin
            r = IW'(1);
        end
        else if (32'(kc) > 32'(MAX_KEYS))
        begin
            r = IW'(MAX_KEYS - 1);
        end
        else
        begin
            r = IW'(kc - kfl_pkg::KCNT_W'(1));
        end
        return r;
    endfunction

    function automatic logic [kfl_pkg::POS_W-1:0] pos_eff(input logic [IW-1:0] idx,
                                                          input logic [IW-1:0] lst,
                                                          input logic [kfl_pkg::POS_W-1:0] raw);
        return (idx >= lst) ? kfl_pkg::UNIT_POS : raw;
    endfunction

    function automatic logic [IW-1:0] next_of(input logic [IW-1:0] idx,
                                              input logic [IW-1:0] lst);
        return (idx >= lst) ? '0 : idx + IW'(1);
    endfunction

    assign last       = last_of(kc_reg);
    assign item_stall = (state_reg != kfl_pkg::ST_IDLE);
    assign cfg_ready  = (state_reg == kfl_pkg::ST_IDLE) && !item_valid;

    assign wr_addr = IW'(key_index);
    assign wr_data = '{pos: key_position, x: key_x, y: key_y, z: key_z};

    always_comb
    begin
        if (phase[kfl_pkg::PHASE_W-1])
        begin
            p_wrap = {1'b0, phase[15:0]};
        end
        else if (phase[kfl_pkg::PHASE_W-2:0] > 23'(kfl_pkg::UNIT_POS))
        begin
            p_wrap = (phase[15:0] == 16'h0) ? kfl_pkg::UNIT_POS : {1'b0, phase[15:0]};
        end
        else
        begin
            p_wrap = phase[kfl_pkg::POS_W-1:0];
        end
    end

    always_comb
    begin
        logic [IW-1:0] cc, nn;
        logic [kfl_pkg::POS_W-1:0] pc, pn;
        logic signed [kfl_pkg::PROD_W-1:0] aprod;
        logic signed [kfl_pkg::NUM_W-1:0]  aden;
        logic signed [kfl_pkg::RES_W-1:0]  sq;
        logic signed [kfl_pkg::RES_W-1:0]  res [3];

        state_next  = state_reg;
        kc_next     = kc_reg;
        cursor_next = cursor_reg;
        c_next      = c_reg;
        n_next      = n_reg;
        p_next      = p_reg;
        posc_next   = posc_reg;
        posn_next   = posn_reg;
        ent_c_next  = ent_c_reg;
        ent_n_next  = ent_n_reg;
        num_next    = num_reg;
        den_next    = den_reg;
        base_next   = base_reg;
        diff_next   = diff_reg;
        prod_next   = prod_reg;
        neg_next    = neg_reg;
        zero_next   = zero_reg;
        ox_next     = ox_reg;
        oy_next     = oy_reg;
        oz_next     = oz_reg;
        zs_next     = zs_reg;
        ov_next     = ov_reg;
        mem_we      = 1'b0;
        rd_addr     = '0;
        cc          = '0;
        nn          = '0;
        pc          = '0;
        pn          = '0;
        aprod       = '0;
        aden        = '0;
        sq          = '0;
        for (int a = 0; a < 3; a++)
        begin
            div_req[a] = '0;
            res[a]     = '0;
        end

        if (ov_reg && !result_stall)
        begin
            ov_next = 1'b0;
        end

        unique case (state_reg)
            kfl_pkg::ST_IDLE:
            begin
                if (cfg_valid && cfg_ready)
                begin
                    kc_next     = key_count;
                    cursor_next = last_of(key_count);
                end
                if (item_valid)
                begin
                    if (action == kfl_pkg::ACT_LOAD)
                    begin
                        mem_we = (32'(key_index) < 32'(MAX_KEYS));
                    end
                    else
                    begin
                        cc         = (cursor_reg > last) ? last : cursor_reg;
                        p_next     = p_wrap;
                        c_next     = cc;
                        rd_addr    = cc;
                        state_next = kfl_pkg::ST_CUR;
                    end
                end
            end
            kfl_pkg::ST_CUR:
            begin
                pc         = pos_eff(c_reg, last, rd_data.pos);
                cc         = (p_reg < pc) ? last : c_reg;
                nn         = next_of(cc, last);
                c_next     = cc;
                n_next     = nn;
                rd_addr    = nn;
                state_next = kfl_pkg::ST_NXT;
            end
            kfl_pkg::ST_NXT:
            begin
                pn = pos_eff(n_reg, last, rd_data.pos);
                if ((n_reg == last) || !(p_reg > pn))
                begin
                    cursor_next = c_reg;
                    ent_n_next  = rd_data;
                    posn_next   = pn;
                    rd_addr     = c_reg;
                    state_next  = kfl_pkg::ST_RDC;
                end
                else
                begin
                    nn      = next_of(n_reg, last);
                    c_next  = n_reg;
                    n_next  = nn;
                    rd_addr = nn;
                end
            end
            kfl_pkg::ST_RDC:
            begin
                ent_c_next = rd_data;
                posc_next  = pos_eff(c_reg, last, rd_data.pos);
                rd_addr    = '0;
                state_next = kfl_pkg::ST_RD0;
            end
            kfl_pkg::ST_RD0:
            begin
                num_next  = $signed({1'b0, p_reg}) - $signed({1'b0, posc_reg});
                den_next  = $signed({1'b0, posn_reg}) - $signed({1'b0, posc_reg});
                zero_next = (posn_reg == posc_reg);
                for (int a = 0; a < 3; a++)
                begin
                    base_next[a] = kfl_pkg::DIFF_W'(kfl_pkg::axis_of(ent_c_reg, a))
                                 - kfl_pkg::DIFF_W'(kfl_pkg::axis_of(rd_data, a));
                    diff_next[a] = kfl_pkg::DIFF_W'(kfl_pkg::axis_of(ent_n_reg, a))
                                 - kfl_pkg::DIFF_W'(kfl_pkg::axis_of(ent_c_reg, a));
                end
                state_next = (posn_reg == posc_reg) ? kfl_pkg::ST_FIN : kfl_pkg::ST_MUL;
            end
            kfl_pkg::ST_MUL:
            begin
                for (int a = 0; a < 3; a++)
                begin
                    prod_next[a] = diff_reg[a] * num_reg;
                end
                state_next = kfl_pkg::ST_PREP;
            end
            kfl_pkg::ST_PREP:
            begin
                aden = den_reg[kfl_pkg::NUM_W-1] ? -den_reg : den_reg;
                for (int a = 0; a < 3; a++)
                begin
                    aprod = prod_reg[a][kfl_pkg::PROD_W-1] ? -prod_reg[a] : prod_reg[a];
                    div_req[a].start    = 1'b1;
                    div_req[a].dividend = aprod[kfl_pkg::DVD_W-1:0]
                                        + kfl_pkg::DVD_W'(aden[kfl_pkg::NUM_W-1:1]);
                    div_req[a].divisor  = aden[kfl_pkg::DVS_W-1:0];
                    neg_next[a] = prod_reg[a][kfl_pkg::PROD_W-1] ^ den_reg[kfl_pkg::NUM_W-1];
                end
                state_next = kfl_pkg::ST_DIV;
            end
            kfl_pkg::ST_DIV:
            begin
                if (div_busy == 3'b000)
                begin
                    state_next = kfl_pkg::ST_FIN;
                end
            end
            kfl_pkg::ST_FIN:
            begin
                if (!ov_reg || !result_stall)
                begin
                    for (int a = 0; a < 3; a++)
                    begin
                        sq = zero_reg ? '0 : $signed({3'b000, div_quo[a]});
                        if (neg_reg[a])
                        begin
                            sq = -sq;
                        end
                        res[a] = kfl_pkg::RES_W'(base_reg[a]) + sq;
                    end
                    ox_next    = kfl_pkg::sat32(res[0]);
                    oy_next    = kfl_pkg::sat32(-res[2]);
                    oz_next    = kfl_pkg::sat32(res[1]);
                    zs_next    = zero_reg;
                    ov_next    = 1'b1;
                    state_next = kfl_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kfl_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= kfl_pkg::ST_IDLE;
            kc_reg     <= kfl_pkg::KCNT_W'(2);
            cursor_reg <= IW'(1);
            ov_reg     <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            kc_reg     <= kc_next;
            cursor_reg <= cursor_next;
            ov_reg     <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        n_reg     <= n_next;
        p_reg     <= p_next;
        posc_reg  <= posc_next;
        posn_reg  <= posn_next;
        ent_c_reg <= ent_c_next;
        ent_n_reg <= ent_n_next;
        num_reg   <= num_next;
        den_reg   <= den_next;
        base_reg  <= base_next;
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        neg_reg   <= neg_next;
        zero_reg  <= zero_next;
        ox_reg    <= ox_next;
        oy_reg    <= oy_next;
        oz_reg    <= oz_next;
        zs_reg    <= zs_next;
    end

    kfl_key_ram #(
        .DEPTH (MAX_KEYS),
        .AW    (IW)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (wr_addr),
        .wdata (wr_data),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    for (genvar g = 0; g < 3; g++)
    begin : g_div
        kfl_divider u_div (
            .clk      (clk),
            .rst_n    (rst_n),
            .req      (div_req[g]),
            .busy     (div_busy[g]),
            .quotient (div_quo[g])
        );
    end

    assign result_valid = ov_reg;
    assign out_x        = ox_reg;
    assign out_y        = oy_reg;
    assign out_z        = oz_reg;
    assign zero_span    = zs_reg;

endmodule

// ----- src/kfl_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the keyframe sampler, bound to the top level.
// Depends on kfl_pkg for field widths.
module kfl_checker (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               cfg_valid,
    input logic                               cfg_ready,
    input logic                               item_valid,
    input logic                               item_stall,
    input logic                               action,
    input logic                               result_valid,
    input logic                               result_stall,
    input logic [kfl_pkg::COORD_W-1:0]        out_x,
    input logic                               zero_span
);

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(out_x) && $stable(zero_span))
        else $error("stalled result word changed");

    a_load_no_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && action == kfl_pkg::ACT_LOAD |=> !$rose(result_valid))
        else $error("load word produced a result");

    a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && action == kfl_pkg::ACT_SAMPLE |=> item_stall)
        else $error("sample word did not occupy the sampler");

    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |-> !item_stall)
        else $error("configuration taken while busy");

endmodule

bind keyframe_translation_lerp_sampler kfl_checker u_kfl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .action       (action),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .out_x        (out_x),
    .zero_span    (zero_span)
);

// ----- bench/keyframe_translation_lerp_sampler_tb.sv -----
`timescale 1ns / 1ps
// Testbench for keyframe_translation_lerp_sampler: random and directed key loads and samples,
// each result checked against an in-bench predictor of the interpolated, origin-relative point.
// Depends on kfl_pkg and the sampler RTL only.
module keyframe_translation_lerp_sampler_tb;

    localparam int NKEYS = 64;
    localparam longint UNIT = 65536;
    localparam int SETTLE_CYCLES = 80;

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic        zs;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [kfl_pkg::KCNT_W-1:0] key_count = '0;
    logic item_valid = 1'b0;
    logic item_stall;
    logic action = kfl_pkg::ACT_LOAD;
    logic [kfl_pkg::KIDX_W-1:0] key_index = '0;
    logic [kfl_pkg::POS_W-1:0] key_position = '0;
    logic signed [kfl_pkg::COORD_W-1:0] key_x = '0;
    logic signed [kfl_pkg::COORD_W-1:0] key_y = '0;
    logic signed [kfl_pkg::COORD_W-1:0] key_z = '0;
    logic signed [kfl_pkg::PHASE_W-1:0] phase = '0;
    logic result_valid;
    logic result_stall = 1'b0;
    logic signed [kfl_pkg::COORD_W-1:0] out_x;
    logic signed [kfl_pkg::COORD_W-1:0] out_y;
    logic signed [kfl_pkg::COORD_W-1:0] out_z;
    logic zero_span;

    keyframe_translation_lerp_sampler u_top (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .key_count(key_count),
        .item_valid(item_valid), .item_stall(item_stall),
        .action(action), .key_index(key_index), .key_position(key_position),
        .key_x(key_x), .key_y(key_y), .key_z(key_z), .phase(phase),
        .result_valid(result_valid), .result_stall(result_stall),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .zero_span(zero_span)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    logic [kfl_pkg::POS_W-1:0]   tbl_pos [NKEYS];
    logic [kfl_pkg::COORD_W-1:0] tbl_x [NKEYS];
    logic [kfl_pkg::COORD_W-1:0] tbl_y [NKEYS];
    logic [kfl_pkg::COORD_W-1:0] tbl_z [NKEYS];
    int unsigned kc_setting = 2;
    int unsigned cursor = 1;
    point_t pending_points[$];
    int errors = 0;
    int loads_sent = 0;
    int samples_sent = 0;
    int results_seen = 0;
    int zero_spans_seen = 0;
    int stall_left = 0;
    bit quiet = 1'b0;

    function automatic int unsigned last_key();
        int unsigned n;
        n = (kc_setting < 2) ? 2 : ((kc_setting > NKEYS) ? NKEYS : kc_setting);
        return n - 1;
    endfunction

    function automatic longint pos_at(int unsigned i, int unsigned lst);
        return (i >= lst) ? UNIT : longint'(tbl_pos[i]);
    endfunction

    function automatic longint div_round(longint a, longint b);
        longint ma;
        longint mb;
        longint q;
        ma = (a < 0) ? -a : a;
        mb = (b < 0) ? -b : b;
        q = (ma + mb / 2) / mb;
        return ((a < 0) != (b < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clip32(longint v);
        if (v > 64'sd2147483647)
        begin
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            return 32'h80000000;
        end
        return v[31:0];
    endfunction

    function automatic longint axis_lerp(logic [31:0] vc, logic [31:0] vn, logic [31:0] vo,
                                         longint num, longint den);
        longint c;
        longint n;
        longint o;
        c = longint'($signed(vc));
        n = longint'($signed(vn));
        o = longint'($signed(vo));
        if (den == 0)
        begin
            return c - o;
        end
        return c - o + div_round((n - c) * num, den);
    endfunction

    task automatic predict_sample(input logic [kfl_pkg::PHASE_W-1:0] ph);
        longint p;
        longint num;
        longint den;
        int unsigned lst;
        int unsigned c;
        int unsigned n;
        point_t r;
        p = longint'($signed(ph));
        if (p < 0)
        begin
            p = p & 64'hffff;
        end
        else if (p > UNIT)
        begin
            p = p & 64'hffff;
            if (p == 0)
            begin
                p = UNIT;
            end
        end
        lst = last_key();
        c = (cursor > lst) ? lst : cursor;
        if (p < pos_at(c, lst))
        begin
            c = lst;
        end
        forever
        begin
            n = (c >= lst) ? 0 : c + 1;
            if (n == lst || !(p > pos_at(n, lst)))
            begin
                break;
            end
            c = n;
        end
        cursor = c;
        num = p - pos_at(c, lst);
        den = pos_at(n, lst) - pos_at(c, lst);
        r.x = clip32(axis_lerp(tbl_x[c], tbl_x[n], tbl_x[0], num, den));
        r.y = clip32(-axis_lerp(tbl_z[c], tbl_z[n], tbl_z[0], num, den));
        r.z = clip32(axis_lerp(tbl_y[c], tbl_y[n], tbl_y[0], num, den));
        r.zs = (den == 0);
        pending_points.push_back(r);
    endtask

    task automatic send_word(input logic act, input logic [kfl_pkg::KIDX_W-1:0] idx,
                             input logic [kfl_pkg::POS_W-1:0] kp, input logic [31:0] vx,
                             input logic [31:0] vy, input logic [31:0] vz,
                             input logic [kfl_pkg::PHASE_W-1:0] ph);
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid <= 1'b1;
        action <= act;
        key_index <= idx;
        key_position <= kp;
        key_x <= vx;
        key_y <= vy;
        key_z <= vz;
        phase <= ph;
        do
        begin
            @(posedge clk);
        end
        while (item_stall);
        if (act == kfl_pkg::ACT_LOAD)
        begin
            tbl_pos[idx] = kp;
            tbl_x[idx] = vx;
            tbl_y[idx] = vy;
            tbl_z[idx] = vz;
            loads_sent++;
        end
        else
        begin
            predict_sample(ph);
            samples_sent++;
        end
    endtask

    task automatic load_key(input int idx, input logic [kfl_pkg::POS_W-1:0] kp,
                            input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz);
        send_word(kfl_pkg::ACT_LOAD, idx[kfl_pkg::KIDX_W-1:0], kp, vx, vy, vz,
                  kfl_pkg::PHASE_W'($urandom));
    endtask

    task automatic sample_at(input logic [kfl_pkg::PHASE_W-1:0] ph);
        send_word(kfl_pkg::ACT_SAMPLE, kfl_pkg::KIDX_W'($urandom), kfl_pkg::POS_W'($urandom),
                  $urandom, $urandom, $urandom, ph);
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        while (pending_points.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_key_count(input logic [kfl_pkg::KCNT_W-1:0] v);
        drain();
        cfg_valid <= 1'b1;
        key_count <= v;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        kc_setting = 32'(v);
        cursor = last_key();
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return $urandom_range(0, 400000) - 200000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [kfl_pkg::PHASE_W-1:0] rand_phase();
        int k;
        case ($urandom_range(0, 9))
            0: return kfl_pkg::PHASE_W'($urandom);
            1:
            begin
                k = $urandom_range(0, 6) - 3;
                return kfl_pkg::PHASE_W'(k * 65536);
            end
            2: return kfl_pkg::PHASE_W'($urandom_range(0, 6 * 65536) - 3 * 65536);
            default: return kfl_pkg::PHASE_W'($urandom_range(0, 65536));
        endcase
    endfunction

    task automatic load_track(input int n);
        int unsigned p;
        p = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2000) : 0;
        for (int i = 0; i < n; i++)
        begin
            load_key(i, kfl_pkg::POS_W'(p), rand_coord(), rand_coord(), rand_coord());
            case ($urandom_range(0, 5))
                0: p = p;
                1: p = p + $urandom_range(0, 65536);
                default: p = p + $urandom_range(1, 2 * 65536 / n);
            endcase
            if (p > UNIT)
            begin
                p = UNIT;
            end
        end
    endtask

    task automatic fill_table();
        for (int i = 0; i < NKEYS; i++)
        begin
            load_key(i, kfl_pkg::POS_W'(i * 1024), rand_coord(), rand_coord(), rand_coord());
        end
    endtask

    task automatic test_extremes();
        logic [kfl_pkg::PHASE_W-1:0] phases [12];
        phases = '{24'h000000, 24'h010000, 24'h008000, 24'hff0000, 24'h020000, 24'h7fffff,
                   24'h800000, 24'h000001, 24'hffffff, 24'h018000, 24'hfe8000, 24'h00ffff};
        load_key(0, 17'h00000, 32'h80000000, 32'h7fffffff, 32'h80000000);
        load_key(1, 17'h1ffff, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        foreach (phases[i])
        begin
            sample_at(phases[i]);
        end
        load_key(0, kfl_pkg::UNIT_POS, 32'h00010000, 32'hfffe0000, 32'h00030000);
        sample_at(24'h010000);
        sample_at(24'h004000);
        load_key(0, 17'h0c000, 32'h12345678, 32'h0, 32'hedcba987);
        sample_at(24'h002000);
        sample_at(24'h00e000);
    endtask

    task automatic test_key_counts();
        logic [kfl_pkg::KCNT_W-1:0] counts [7];
        int n;
        counts = '{7'd0, 7'd1, 7'd64, 7'd127, 7'd5, 7'd2, 7'd17};
        foreach (counts[i])
        begin
            write_key_count(counts[i]);
            n = last_key() + 1;
            load_track(n);
            for (int j = 0; j < 12; j++)
            begin
                sample_at(rand_phase());
            end
        end
    endtask

    task automatic run_random_phase(input logic [kfl_pkg::KCNT_W-1:0] kc, input int words);
        int n;
        write_key_count(kc);
        n = last_key() + 1;
        load_track(n);
        for (int j = 0; j < words; j++)
        begin
            case ($urandom_range(0, 39))
                0: load_key($urandom_range(0, NKEYS - 1),
                            kfl_pkg::POS_W'($urandom_range(0, 65536)),
                            rand_coord(), rand_coord(), rand_coord());
                1: load_track(n);
                default: sample_at(rand_phase());
            endcase
        end
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 8; ph++)
        begin
            if (ph == 6)
            begin
                quiet = 1'b1;
            end
            run_random_phase((ph % 3 == 0) ? kfl_pkg::KCNT_W'($urandom_range(0, 127))
                                           : kfl_pkg::KCNT_W'($urandom_range(2, 12)), 100);
            if (ph == 3)
            begin
                drain();
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (quiet)
        begin
            result_stall <= 1'b0;
            stall_left = 0;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            if (stall_left == 0)
            begin
                result_stall <= 1'b0;
            end
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            result_stall <= 1'b1;
            stall_left = $urandom_range(1, 4);
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && result_valid && !result_stall)
        begin
            results_seen++;
            if (zero_span)
            begin
                zero_spans_seen++;
            end
            if (pending_points.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                e = pending_points.pop_front();
                if (out_x !== e.x)
                begin
                    $error("out_x expected %h actual %h", e.x, out_x);
                    errors++;
                end
                if (out_y !== e.y)
                begin
                    $error("out_y expected %h actual %h", e.y, out_y);
                    errors++;
                end
                if (out_z !== e.z)
                begin
                    $error("out_z expected %h actual %h", e.z, out_z);
                    errors++;
                end
                if (zero_span !== e.zs)
                begin
                    $error("zero_span expected %b actual %b", e.zs, zero_span);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        #(12 * 3000000);
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_extremes();
        fill_table();
        test_key_counts();
        test_random();
        drain();
        $display("Sent %0d key loads and %0d samples over many key counts.",
                 loads_sent, samples_sent);
        $display("Checked %0d result words, %0d of them zero span.",
                 results_seen, zero_spans_seen);
        if (errors == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ----- filelist.f -----
src/kfl_pkg.sv
src/kfl_key_ram.sv
src/kfl_divider.sv
src/keyframe_translation_lerp_sampler.sv
src/kfl_checker.sv
bench/keyframe_translation_lerp_sampler_tb.sv
